[rtl/bwat_pkg.sv]
// Shared types, constants and codes of the address translation window table.
package bwat_pkg;

  localparam int DefWindowCount   = 8;
  localparam int DefDevAddrBits   = 40;
  localparam int HostW            = 48;
  localparam int BaseW            = 40;
  localparam int SizeW            = 41;
  localparam int EndW             = 42;
  localparam int LenW             = 24;
  localparam int ExpW             = 32;
  localparam int CmpW             = 50;
  localparam int ForceBit         = 37;

  localparam logic [5:0] ForceIsland  = 6'h18;
  localparam logic [3:0] ForceTarget  = 4'h7;
  localparam logic [5:0] SpanMin      = 6'd12;
  localparam logic [5:0] SpanMax      = 6'd37;
  localparam logic [5:0] SpanResetVal = 6'd21;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StNoWindow  = 2'd1,
    StMisalign  = 2'd2,
    StUnmapped  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ResSetupUnmapped,
    ResSetupOob,
    ResSetupOk,
    ResMiss,
    ResTranslated
  } res_kind_e;

  typedef enum logic {
    RegHostBase = 1'b0,
    RegSpanLog2 = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [HostW-1:0] host_base;
    logic [5:0]       span_log2;
  } bwat_cfg_t;

  typedef struct packed {
    logic [3:0]       tgt;
    logic [BaseW-1:0] base;
    logic [EndW-1:0]  win_end;
    logic [ExpW-1:0]  expansion;
  } bwat_entry_t;

  typedef struct packed {
    logic      capture;
    logic      walk_clr;
    logic      walk_inc;
    logic      rd_en;
    logic      rd_setup;
    logic      wr_en;
    logic      off_en;
    logic      res_en;
    res_kind_e res_kind;
  } bwat_cmd_t;

  typedef struct packed {
    logic host_zero;
    logic idx_oob;
    logic match;
    logic walk_done;
  } bwat_stat_t;

endpackage

[rtl/bar_window_address_translator.sv]
// A setup item registers its result in the SetupRd state when it fails, else in SetupWr.
// An access item walks the table one entry per cycle through the registered read port:
// a hit on entry k passes the Xlate state before its result; a miss ends the walk.
// One item is worked on at a time; a new item may start in the cycle that shows the result.
// Each result is shown for one cycle on done_o and cannot be held off by the receiver.
// Reset clears the host base and all valid bits, and sets the span exponent to 21.
module bar_window_address_translator
  import bwat_pkg::*;
#(
  parameter int WINDOW_COUNT        = DefWindowCount,
  parameter int DEVICE_ADDRESS_BITS = DefDevAddrBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [63:0]                    pwdata,
  output logic [63:0]                    prdata,
  output logic                           pready,
  input  logic                           start,
  output logic                           busy,
  input  logic                           operation_i,
  input  logic [3:0]                     target_i,
  input  logic [5:0]                     island_i,
  input  logic [DEVICE_ADDRESS_BITS-1:0] address_i,
  input  logic [LenW-1:0]                length_i,
  input  logic [2:0]                     window_index_i,
  input  logic [BaseW-1:0]               window_base_i,
  input  logic [SizeW-1:0]               window_size_i,
  input  logic [ExpW-1:0]                expansion_word_i,
  output logic                           done_o,
  output logic [1:0]                     status_o,
  output logic [2:0]                     hit_index_o,
  output logic [HostW-1:0]               host_address_o,
  output logic [LenW-1:0]                transfer_length_o,
  output logic                           expansion_changed_o,
  output logic [ExpW-1:0]                expansion_value_o
);

  bwat_cfg_t  cfg;
  bwat_cmd_t  cmd;
  bwat_stat_t stat;

  bwat_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bwat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .operation_i (operation_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy        (busy),
    .done_o      (done_o)
  );

  bwat_dpath #(
    .WINDOW_COUNT        (WINDOW_COUNT),
    .DEVICE_ADDRESS_BITS (DEVICE_ADDRESS_BITS)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .cfg_i               (cfg),
    .target_i            (target_i),
    .island_i            (island_i),
    .address_i           (address_i),
    .length_i            (length_i),
    .window_index_i      (window_index_i),
    .window_base_i       (window_base_i),
    .window_size_i       (window_size_i),
    .expansion_word_i    (expansion_word_i),
    .status_o            (status_o),
    .hit_index_o         (hit_index_o),
    .host_address_o      (host_address_o),
    .transfer_length_o   (transfer_length_o),
    .expansion_changed_o (expansion_changed_o),
    .expansion_value_o   (expansion_value_o)
  );

endmodule

[rtl/bwat_regs.sv]
// Configuration register port holding the host base and the span exponent.
module bwat_regs
  import bwat_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  output bwat_cfg_t        cfg_o
);

  logic [HostW-1:0] host_base_q;
  logic [5:0]       span_log2_q;
  logic             wr_en;
  reg_idx_e         reg_idx;

  assign reg_idx = reg_idx_e'(paddr[3]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_base_q <= '0;
      span_log2_q <= SpanResetVal;
    end else if (wr_en) begin
      case (reg_idx)
        RegHostBase: host_base_q <= pwdata[HostW-1:0];
        RegSpanLog2: span_log2_q <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegHostBase: prdata = {{(64-HostW){1'b0}}, host_base_q};
      RegSpanLog2: prdata = {58'd0, span_log2_q};
      default:     prdata = '0;
    endcase
  end

  assign cfg_o.host_base = host_base_q;
  assign cfg_o.span_log2 = span_log2_q;

endmodule

[rtl/bwat_dpath.sv]
// Datapath: item capture, window table memory, range checks and address translation.
module bwat_dpath
  import bwat_pkg::*;
#(
  parameter int WINDOW_COUNT        = DefWindowCount,
  parameter int DEVICE_ADDRESS_BITS = DefDevAddrBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bwat_cmd_t                      cmd_i,
  output bwat_stat_t                     stat_o,
  input  bwat_cfg_t                      cfg_i,
  input  logic [3:0]                     target_i,
  input  logic [5:0]                     island_i,
  input  logic [DEVICE_ADDRESS_BITS-1:0] address_i,
  input  logic [LenW-1:0]                length_i,
  input  logic [2:0]                     window_index_i,
  input  logic [BaseW-1:0]               window_base_i,
  input  logic [SizeW-1:0]               window_size_i,
  input  logic [ExpW-1:0]                expansion_word_i,
  output logic [1:0]                     status_o,
  output logic [2:0]                     hit_index_o,
  output logic [HostW-1:0]               host_address_o,
  output logic [LenW-1:0]                transfer_length_o,
  output logic                           expansion_changed_o,
  output logic [ExpW-1:0]                expansion_value_o
);

  localparam int IdxW = (WINDOW_COUNT > 1) ? $clog2(WINDOW_COUNT) : 1;
  localparam int CntW = $clog2(WINDOW_COUNT + 1);
  localparam logic [HostW:0] DevMask = (HostW'(1) << DEVICE_ADDRESS_BITS) - (HostW + 1)'(1);
  localparam logic [5:0] WinCount = 6'(WINDOW_COUNT);

  logic [3:0]        tgt_q;
  logic [HostW-1:0]  addr_q;
  logic [CmpW-1:0]   addr_end_q;
  logic [LenW-1:0]   len_q;
  logic [2:0]        widx_q;
  logic [BaseW-1:0]  wbase_q;
  logic [SizeW-1:0]  wsize_q;
  logic [ExpW-1:0]   wexp_q;

  logic [CntW-1:0]   walk_q;
  bwat_entry_t       mem_q [WINDOW_COUNT];
  logic [WINDOW_COUNT-1:0] valid_q;
  bwat_entry_t       ent_q;
  logic              ent_vld_q;
  logic [IdxW-1:0]   ent_idx_q;
  logic [IdxW-1:0]   hit_q;
  logic [HostW-1:0]  off_q;

  logic [HostW-1:0]  addr_in;
  logic [IdxW-1:0]   rd_addr;
  logic [IdxW-1:0]   wr_addr;
  logic [5:0]        span_sl;
  logic [HostW-1:0]  span_mask;
  logic [HostW-1:0]  host_addr;
  logic [ExpW-1:0]   exp_old;
  bwat_entry_t       wr_entry;

  always_comb begin
    addr_in = HostW'(address_i);
    if (island_i == ForceIsland && target_i == ForceTarget) begin
      addr_in = addr_in | (HostW'(1) << ForceBit);
    end
    addr_in = addr_in & DevMask[HostW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      tgt_q      <= target_i;
      addr_q     <= addr_in;
      addr_end_q <= CmpW'(addr_in) + CmpW'(length_i);
      len_q      <= length_i;
      widx_q     <= window_index_i;
      wbase_q    <= window_base_i;
      wsize_q    <= window_size_i;
      wexp_q     <= expansion_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q <= '0;
    end else if (cmd_i.walk_clr) begin
      walk_q <= '0;
    end else if (cmd_i.walk_inc) begin
      walk_q <= walk_q + CntW'(1);
    end
  end

  assign rd_addr = cmd_i.rd_setup ? IdxW'(widx_q) : IdxW'(walk_q);
  assign wr_addr = IdxW'(widx_q);

  assign wr_entry.tgt       = tgt_q;
  assign wr_entry.base      = wbase_q;
  assign wr_entry.win_end   = EndW'(wbase_q) + EndW'(wsize_q);
  assign wr_entry.expansion = wexp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= wr_entry;
    end
    if (cmd_i.rd_en) begin
      ent_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      ent_vld_q <= 1'b0;
      ent_idx_q <= '0;
    end else begin
      if (cmd_i.wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        ent_vld_q <= valid_q[rd_addr];
        ent_idx_q <= rd_addr;
      end
    end
  end

  assign span_sl   = (cfg_i.span_log2 < SpanMin) ? SpanMin :
                     (cfg_i.span_log2 > SpanMax) ? SpanMax : cfg_i.span_log2;
  assign span_mask = (HostW'(1) << span_sl) - HostW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.off_en) begin
      hit_q <= ent_idx_q;
      off_q <= (HostW'(ent_idx_q) << span_sl) + (addr_q & span_mask);
    end
  end

  assign host_addr = cfg_i.host_base + off_q;
  assign exp_old   = ent_vld_q ? ent_q.expansion : '0;

  assign stat_o.host_zero = (cfg_i.host_base == '0);
  assign stat_o.idx_oob   = ({3'd0, widx_q} >= WinCount);
  assign stat_o.walk_done = (walk_q == CntW'(WINDOW_COUNT));
  assign stat_o.match     = ent_vld_q && (ent_q.tgt == tgt_q) &&
                            (CmpW'(addr_q) >= CmpW'(ent_q.base)) &&
                            (addr_end_q <= CmpW'(ent_q.win_end));

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_en) begin
      status_o            <= StOk;
      hit_index_o         <= '0;
      host_address_o      <= '0;
      transfer_length_o   <= '0;
      expansion_changed_o <= 1'b0;
      expansion_value_o   <= '0;
      case (cmd_i.res_kind)
        ResSetupUnmapped: begin
          status_o    <= StUnmapped;
          hit_index_o <= widx_q;
        end
        ResSetupOob: begin
          status_o    <= StNoWindow;
          hit_index_o <= widx_q;
        end
        ResSetupOk: begin
          hit_index_o         <= widx_q;
          expansion_changed_o <= (exp_old != wexp_q);
          expansion_value_o   <= wexp_q;
        end
        ResMiss: begin
          status_o <= StNoWindow;
        end
        ResTranslated: begin
          hit_index_o    <= 3'(hit_q);
          host_address_o <= host_addr;
          if (host_addr[2:0] != 3'd0 || len_q[2:0] != 3'd0) begin
            status_o <= StMisalign;
          end else begin
            transfer_length_o <= len_q;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/bwat_ctrl.sv]
// Controller state machine sequencing setup writes and the window table walk.
module bwat_ctrl
  import bwat_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic       operation_i,
  input  bwat_stat_t stat_i,
  output bwat_cmd_t  cmd_o,
  output logic       busy,
  output logic       done_o
);

  typedef enum logic [2:0] {
    Idle,
    SetupRd,
    SetupWr,
    Walk,
    Xlate
  } state_e;

  state_e state_q, state_d;
  logic   prime_q, prime_d;
  logic   done_q;

  always_comb begin
    state_d        = state_q;
    prime_d        = prime_q;
    cmd_o          = '0;
    cmd_o.res_kind = ResMiss;
    case (state_q)
      Idle: begin
        if (start) begin
          cmd_o.capture  = 1'b1;
          cmd_o.walk_clr = 1'b1;
          prime_d        = 1'b0;
          state_d        = operation_i ? SetupRd : Walk;
        end
      end
      SetupRd: begin
        if (stat_i.host_zero) begin
          cmd_o.res_en   = 1'b1;
          cmd_o.res_kind = ResSetupUnmapped;
          state_d        = Idle;
        end else if (stat_i.idx_oob) begin
          cmd_o.res_en   = 1'b1;
          cmd_o.res_kind = ResSetupOob;
          state_d        = Idle;
        end else begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_setup = 1'b1;
          state_d        = SetupWr;
        end
      end
      SetupWr: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.res_en   = 1'b1;
        cmd_o.res_kind = ResSetupOk;
        state_d        = Idle;
      end
      Walk: begin
        cmd_o.rd_en    = !stat_i.walk_done;
        cmd_o.walk_inc = !stat_i.walk_done;
        if (prime_q && stat_i.match) begin
          cmd_o.off_en = 1'b1;
          state_d      = Xlate;
        end else if (stat_i.walk_done) begin
          cmd_o.res_en   = 1'b1;
          cmd_o.res_kind = ResMiss;
          state_d        = Idle;
        end else begin
          prime_d = 1'b1;
        end
      end
      Xlate: begin
        cmd_o.res_en   = 1'b1;
        cmd_o.res_kind = ResTranslated;
        state_d        = Idle;
      end
      default: state_d = Idle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      prime_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      prime_q <= prime_d;
      done_q  <= cmd_o.res_en;
    end
  end

  assign busy   = (state_q != Idle);
  assign done_o = done_q;

endmodule
